### sv/tsb_pkg.sv
`default_nettype none

package tsb_pkg;

  localparam int NAME_W     = 32;
  localparam int SLOT_W     = 5;
  localparam int NSLOT_W    = 6;
  localparam int QUAD_W     = 16;
  localparam int LIMIT_W    = NSLOT_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_SLOTS_DEF = 32;

  localparam logic [NSLOT_W-1:0] SLOT_LIMIT_RST = NSLOT_W'(32);
  localparam logic [QUAD_W-1:0]  QUAD_CAP_RST   = QUAD_W'(1024);

  // Command codes carried with each request
  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUAD_CAP   = CFG_IDX_W'(1);

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the accepted request
    logic match;    // capture the slot compare vector
    logic resolve;  // commit state and load the result register
  } tsb_cmd_t;

endpackage

`default_nettype wire

### sv/tsb_ctrl.sv
`default_nettype none

module tsb_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire              out_tready,
  output tsb_pkg::tsb_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_RESOLVE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (out_free) begin
          cmd.resolve    = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_valid_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_RESOLVE))
    else $error("result raised without a resolve step");
  a_stall_holds_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE && out_tvalid_r && !out_tready) |=> state_r == S_RESOLVE)
    else $error("resolve left while result register occupied");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> out_tvalid_r)
    else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

### sv/tsb_dp.sv
`default_nettype none

module tsb_dp #(
  parameter int MAX_SLOTS = tsb_pkg::MAX_SLOTS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  tsb_pkg::tsb_cmd_t                 cmd,
  input  wire                               cfg_wr_en,
  input  wire  [tsb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [tsb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                               item_cmd,
  input  wire                               item_textured,
  input  wire  [tsb_pkg::NAME_W-1:0]        item_name,
  output logic [tsb_pkg::SLOT_W-1:0]        res_slot,
  output logic                              res_flushed,
  output logic [tsb_pkg::QUAD_W-1:0]        res_quads,
  output logic [tsb_pkg::NSLOT_W-1:0]       res_textures
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [tsb_pkg::LIMIT_W-1:0] MAX_LIM = tsb_pkg::LIMIT_W'(MAX_SLOTS);

  logic [tsb_pkg::NSLOT_W-1:0] slot_limit_r;
  logic [tsb_pkg::QUAD_W-1:0]  quad_cap_r;
  logic [tsb_pkg::NSLOT_W-1:0] next_slot_r, next_slot_nxt;
  logic [tsb_pkg::QUAD_W-1:0]  quad_count_r, quad_count_nxt;

  logic                        cmd_r;
  logic                        textured_r;
  logic [tsb_pkg::NAME_W-1:0]  name_r;

  logic [tsb_pkg::NAME_W-1:0]  names_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]        match_vec;
  logic [MAX_SLOTS-1:0]        match_r;

  logic [tsb_pkg::LIMIT_W-1:0] limit;
  logic                        buffer_full;
  logic                        table_full;
  logic                        hit;
  logic [tsb_pkg::NSLOT_W-1:0] hit_idx;
  logic                        do_flush;
  logic                        wr_en;
  logic [tsb_pkg::NSLOT_W-1:0] wr_slot;
  logic [tsb_pkg::NSLOT_W-1:0] slot_sel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r <= tsb_pkg::SLOT_LIMIT_RST;
      quad_cap_r   <= tsb_pkg::QUAD_CAP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tsb_pkg::REG_SLOT_LIMIT: slot_limit_r <= cfg_wdata[tsb_pkg::NSLOT_W-1:0];
        tsb_pkg::REG_QUAD_CAP:   quad_cap_r   <= cfg_wdata[tsb_pkg::QUAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= item_cmd;
      textured_r <= item_textured;
      name_r     <= item_name;
    end
  end

  // Compare against bound slots 1 .. next_slot-1
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cmp
    if (i == 0) begin : g_reserved
      assign match_vec[i] = 1'b0;
    end else begin : g_slot
      assign match_vec[i] = (names_r[i] == name_r) &&
                            (tsb_pkg::NSLOT_W'(i) < next_slot_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '0;
    end else if (cmd.match) begin
      match_r <= match_vec;
    end
  end

  // Names are unique within a batch, so an OR of indexes encodes the hit
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (match_r[i]) begin
        hit_idx = hit_idx | tsb_pkg::NSLOT_W'(i);
      end
    end
  end
  assign hit = |match_r;

  assign limit = ({1'b0, slot_limit_r} > MAX_LIM) ? MAX_LIM : {1'b0, slot_limit_r};
  assign buffer_full = ({1'b0, quad_count_r} + 17'd1) >= {1'b0, quad_cap_r};
  assign table_full  = {1'b0, next_slot_r} >= limit;

  always_comb begin
    do_flush       = 1'b0;
    wr_en          = 1'b0;
    wr_slot        = next_slot_r;
    slot_sel       = '0;
    next_slot_nxt  = next_slot_r;
    quad_count_nxt = quad_count_r + 16'd1;
    if (cmd_r == tsb_pkg::CMD_FLUSH) begin
      do_flush       = 1'b1;
      next_slot_nxt  = tsb_pkg::NSLOT_W'(1);
      quad_count_nxt = '0;
    end else if (!textured_r) begin
      if (buffer_full) begin
        do_flush       = 1'b1;
        next_slot_nxt  = tsb_pkg::NSLOT_W'(1);
        quad_count_nxt = 16'd1;
      end
    end else if (table_full || buffer_full) begin
      // flush, then bind the texture into slot 1
      do_flush       = 1'b1;
      wr_en          = 1'b1;
      wr_slot        = tsb_pkg::NSLOT_W'(1);
      slot_sel       = tsb_pkg::NSLOT_W'(1);
      next_slot_nxt  = tsb_pkg::NSLOT_W'(2);
      quad_count_nxt = 16'd1;
    end else if (hit) begin
      slot_sel = hit_idx;
    end else begin
      wr_en         = 1'b1;
      slot_sel      = next_slot_r;
      next_slot_nxt = next_slot_r + tsb_pkg::NSLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_slot_r  <= tsb_pkg::NSLOT_W'(1);
      quad_count_r <= '0;
    end else if (cmd.resolve) begin
      next_slot_r  <= next_slot_nxt;
      quad_count_r <= quad_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve && wr_en) begin
      names_r[wr_slot[IDX_W-1:0]] <= name_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      res_slot     <= slot_sel[tsb_pkg::SLOT_W-1:0];
      res_flushed  <= do_flush;
      res_quads    <= do_flush ? quad_count_r : '0;
      res_textures <= do_flush ? next_slot_r : '0;
    end
  end

`ifndef SYNTHESIS
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_r))
    else $error("texture name bound in more than one slot");
  a_next_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_slot_r != '0) && ({1'b0, next_slot_r} <= MAX_LIM))
    else $error("next free slot out of range");
  a_end_batch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resolve && cmd_r == tsb_pkg::CMD_FLUSH) |=>
      (quad_count_r == '0) && (next_slot_r == tsb_pkg::NSLOT_W'(1)))
    else $error("end of batch did not clear the batch state");
`endif

endmodule

`default_nettype wire

### sv/texture_slot_batcher.sv
`default_nettype none

// Texture slot batcher. Each request either submits one quad (in_tuser[0] = 0)
// or ends the batch (in_tuser[0] = 1); in_tuser[1] marks a textured quad and
// in_tdata carries its 32-bit texture name. Every request yields exactly one
// result: the slot the quad was given (0 for untextured quads and for end of
// batch), a flush flag on out_tuser, and for a flush the quad count and the
// number of bound slots (slot 0 included) of the batch that was closed. Slot
// names sit in a register file and are compared in parallel against the
// bound slots; each request passes three steps: accept, compare, resolve. The
// resolve step waits while the previous result is still held in the output
// register, so a stalled output adds its stall time to the next request.
// Write slot_limit (index 0) and quad_capacity (index 1) only while idle.
module texture_slot_batcher #(
  parameter int MAX_SLOTS = tsb_pkg::MAX_SLOTS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // request channel
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [31:0]                    in_tdata,   // [31:0] texture_name
  input  wire  [1:0]                     in_tuser,   // [0] cmd, [1] textured
  // result channel
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [31:0]                    out_tdata,  // [4:0] slot, [20:5] flushed_quads,
                                                     // [26:21] flushed_textures, rest 0
  output logic                           out_tuser,  // [0] flushed
  // configuration writes
  input  wire                            cfg_wr_en,
  input  wire  [tsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [tsb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tsb_pkg::tsb_cmd_t           cmd;
  logic [tsb_pkg::SLOT_W-1:0]  res_slot;
  logic [tsb_pkg::QUAD_W-1:0]  res_quads;
  logic [tsb_pkg::NSLOT_W-1:0] res_textures;

  // Sequence each request: accept, compare, resolve
  tsb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Slot table, batch counters and result register
  tsb_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .item_cmd      (in_tuser[0]),
    .item_textured (in_tuser[1]),
    .item_name     (in_tdata),
    .res_slot      (res_slot),
    .res_flushed   (out_tuser),
    .res_quads     (res_quads),
    .res_textures  (res_textures)
  );

  // Pack result fields, lowest field first, zero fill to 32 bits
  assign out_tdata = {5'd0, res_textures, res_quads, res_slot};

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int SLOT_COUNT       = tsb_pkg::MAX_SLOTS_DEF;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 20;
  localparam int MAX_REPORTS      = 40;

  // One result as the block should return it
  typedef struct packed {
    logic [tsb_pkg::SLOT_W-1:0]  slot;
    logic                        flushed;
    logic [tsb_pkg::QUAD_W-1:0]  quads;
    logic [tsb_pkg::NSLOT_W-1:0] textures;
  } batch_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [31:0]                    in_tdata;   // [31:0] texture_name
  logic [1:0]                     in_tuser;   // [0] cmd, [1] textured
  logic                           out_tvalid;
  logic                           out_tready;
  logic [31:0]                    out_tdata;  // [4:0] slot, [20:5] flushed_quads,
                                              // [26:21] flushed_textures, rest 0
  logic                           out_tuser;  // [0] flushed
  logic                           cfg_wr_en;
  logic [tsb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tsb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Predicted block state, kept in step with every accepted request
  logic [tsb_pkg::NAME_W-1:0]  slot_names_q [SLOT_COUNT];
  logic [tsb_pkg::NSLOT_W-1:0] next_slot_q;
  logic [tsb_pkg::QUAD_W-1:0]  quad_count_q;
  logic [tsb_pkg::NSLOT_W-1:0] slot_limit_q;
  logic [tsb_pkg::QUAD_W-1:0]  quad_cap_q;

  batch_result_t slot_results_q [$];

  int  mismatch_count = 0;
  int  result_count   = 0;
  int  cycle_count    = 0;
  int  burst_left     = 0;
  bit  steady_feed    = 1'b0;
  bit  long_hold_req  = 1'b0;

  texture_slot_batcher DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the predicted state by one request and return the result it owes.
  // A request closes the batch when it is an end of batch, when the quad
  // buffer has no room left, or when a textured quad finds the slot table
  // full (even if its name is already bound).
  function automatic batch_result_t assign_slot(input logic cmd, input logic textured,
                                                input logic [tsb_pkg::NAME_W-1:0] name);
    batch_result_t res;
    int            eff_limit;
    logic          buffer_full;
    logic          close_now;
    logic          hit;
    int            idx;
    res = '0;
    // Limits above the table depth clamp to the depth
    eff_limit   = (int'(slot_limit_q) > SLOT_COUNT) ? SLOT_COUNT : int'(slot_limit_q);
    buffer_full = (int'(quad_count_q) + 1) >= int'(quad_cap_q);
    close_now   = (cmd == tsb_pkg::CMD_FLUSH) || buffer_full ||
                  (textured && (int'(next_slot_q) >= eff_limit));
    if (close_now) begin
      res.flushed  = 1'b1;
      res.quads    = quad_count_q;
      res.textures = next_slot_q;
      next_slot_q  = tsb_pkg::NSLOT_W'(1);
      quad_count_q = '0;
    end
    if (cmd == tsb_pkg::CMD_SUBMIT) begin
      if (textured && close_now) begin
        // Fresh batch: the name lands in the first free slot
        slot_names_q[1] = name;
        next_slot_q     = tsb_pkg::NSLOT_W'(2);
        res.slot        = tsb_pkg::SLOT_W'(1);
      end else if (textured) begin
        hit = 1'b0;
        for (idx = 1; idx < SLOT_COUNT; idx++) begin
          if (!hit && (idx < int'(next_slot_q)) && (slot_names_q[idx] == name)) begin
            hit      = 1'b1;
            res.slot = tsb_pkg::SLOT_W'(idx);
          end
        end
        if (!hit) begin
          res.slot = next_slot_q[tsb_pkg::SLOT_W-1:0];
          slot_names_q[next_slot_q[tsb_pkg::SLOT_W-1:0]] = name;
          next_slot_q = next_slot_q + tsb_pkg::NSLOT_W'(1);
        end
      end
      quad_count_q = quad_count_q + tsb_pkg::QUAD_W'(1);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t: result %0d: %s is %0h, expected %0h", $time, result_count, what,
               got, want);
    mismatch_count++;
  endtask

  // Offer one request in bursts with random gaps; predict it once it is taken.
  task automatic send_request(input logic cmd, input logic textured,
                              input logic [tsb_pkg::NAME_W-1:0] name);
    int gap;
    if (burst_left == 0) begin
      burst_left = steady_feed ? 64 : $urandom_range(1, 10);
      if (steady_feed)
        gap = 0;
      else if ($urandom_range(0, 7) == 0)
        gap = $urandom_range(4, 14);
      else
        gap = $urandom_range(0, 3);
      if (gap > 0) begin
        // Drop valid for the gap
        if (in_tvalid)
          in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= name;
    in_tuser  <= {textured, cmd};
    do @(posedge clk); while (!in_tready);
    slot_results_q.push_back(assign_slot(cmd, textured, name));
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (slot_results_q.size() != 0);
  endtask

  // Write both registers back to back; call only while idle
  task automatic set_batch_limits(input logic [tsb_pkg::NSLOT_W-1:0] limit,
                                  input logic [tsb_pkg::QUAD_W-1:0] capacity);
    cfg_wr_en <= 1'b1;
    cfg_index <= tsb_pkg::REG_SLOT_LIMIT;
    cfg_wdata <= tsb_pkg::CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_index <= tsb_pkg::REG_QUAD_CAP;
    cfg_wdata <= tsb_pkg::CFG_DATA_W'(capacity);
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    slot_limit_q = limit;
    quad_cap_q   = capacity;
  endtask

  // Reset settings: empty end of batch, untextured quads, name extremes,
  // a hit, and the textured flag riding on an end of batch
  task automatic test_batch_basics();
    send_request(tsb_pkg::CMD_FLUSH, 1'b0, 32'h0);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b0, 32'h1234_5678);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'h0000_0000);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'hFFFF_FFFF);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'h0000_0000);
    send_request(tsb_pkg::CMD_FLUSH, 1'b1, 32'hFFFF_FFFF);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'hAAAA_AAAA);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'h5555_5555);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b0, 32'hFFFF_FFFF);
  endtask

  // Full slot table: flush on a hit, limits below two, limit above the depth
  task automatic test_slot_table_full();
    wait_idle();
    set_batch_limits(tsb_pkg::NSLOT_W'(3), tsb_pkg::QUAD_W'(1024));
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'hA0A0_0001);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'hB0B0_0002);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'hA0A0_0001);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'hB0B0_0002);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'hC0C0_0003);
    wait_idle();
    set_batch_limits(tsb_pkg::NSLOT_W'(0), tsb_pkg::QUAD_W'(1024));
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'h0000_0011);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b0, 32'h0000_0011);
    wait_idle();
    set_batch_limits(tsb_pkg::NSLOT_W'(1), tsb_pkg::QUAD_W'(1024));
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'h0000_0022);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'h0000_0022);
    wait_idle();
    set_batch_limits(tsb_pkg::NSLOT_W'(40), tsb_pkg::QUAD_W'(1024));
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'h0000_0033);
  endtask

  // Quad buffer: capacities zero, one and two, each flushing every submission here
  task automatic test_quad_capacity();
    wait_idle();
    set_batch_limits(tsb_pkg::NSLOT_W'(32), tsb_pkg::QUAD_W'(0));
    send_request(tsb_pkg::CMD_SUBMIT, 1'b0, 32'h0);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'h0000_0044);
    wait_idle();
    set_batch_limits(tsb_pkg::NSLOT_W'(32), tsb_pkg::QUAD_W'(1));
    send_request(tsb_pkg::CMD_SUBMIT, 1'b0, 32'h0);
    wait_idle();
    set_batch_limits(tsb_pkg::NSLOT_W'(32), tsb_pkg::QUAD_W'(2));
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'h0000_0055);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b1, 32'h0000_0055);
    send_request(tsb_pkg::CMD_SUBMIT, 1'b0, 32'h0);
  endtask

  // Mostly quads drawn from a small pool of names so batches see hits,
  // misses and full tables; the rest fresh names, untextured quads and
  // end-of-batch requests
  task automatic run_random_phase(input logic [tsb_pkg::NSLOT_W-1:0] limit,
                                  input logic [tsb_pkg::QUAD_W-1:0] capacity,
                                  input int n_items, input int pool_size,
                                  input int flush_pct);
    logic [tsb_pkg::NAME_W-1:0] name_pool [$];
    int                         pick;
    wait_idle();
    set_batch_limits(limit, capacity);
    steady_feed = ($urandom_range(0, 3) == 0);
    repeat (pool_size) name_pool.push_back($urandom);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < flush_pct)
        send_request(tsb_pkg::CMD_FLUSH, 1'($urandom), $urandom);
      else if (pick < flush_pct + 12)
        send_request(tsb_pkg::CMD_SUBMIT, 1'b0, $urandom);
      else if (pick < flush_pct + 18)
        send_request(tsb_pkg::CMD_SUBMIT, 1'b1, $urandom);
      else
        send_request(tsb_pkg::CMD_SUBMIT, 1'b1,
                     name_pool[$urandom_range(0, pool_size - 1)]);
    end
    steady_feed = 1'b0;
  endtask

  task automatic test_random_batches();
    run_random_phase(tsb_pkg::NSLOT_W'(32), tsb_pkg::QUAD_W'(1024),  80, 48, 0);
    run_random_phase(tsb_pkg::NSLOT_W'(2),  tsb_pkg::QUAD_W'(65535), 40,  4, 3);
    run_random_phase(tsb_pkg::NSLOT_W'(5),  tsb_pkg::QUAD_W'(7),     50,  6, 4);
    run_random_phase(tsb_pkg::NSLOT_W'(32), tsb_pkg::QUAD_W'(2),     30,  8, 4);
    run_random_phase(tsb_pkg::NSLOT_W'(8),  tsb_pkg::QUAD_W'(40),    60, 12, 3);
    run_random_phase(tsb_pkg::NSLOT_W'(0),  tsb_pkg::QUAD_W'(3),     25,  4, 4);
    run_random_phase(tsb_pkg::NSLOT_W'(63), tsb_pkg::QUAD_W'(65535), 50, 40, 2);
    run_random_phase(tsb_pkg::NSLOT_W'(33), tsb_pkg::QUAD_W'(1),     20,  4, 5);
    run_random_phase(tsb_pkg::NSLOT_W'(16), tsb_pkg::QUAD_W'(20),    60, 20, 3);
    run_random_phase(tsb_pkg::NSLOT_W'(1),  tsb_pkg::QUAD_W'(0),     20,  4, 5);
  endtask

  // Stall the result side for a long stretch while requests keep coming,
  // so the block fills and drops in_tready
  task automatic test_output_backpressure();
    wait_idle();
    set_batch_limits(tsb_pkg::NSLOT_W'(12), tsb_pkg::QUAD_W'(30));
    long_hold_req = 1'b1;
    steady_feed   = 1'b1;
    repeat (40)
      send_request(tsb_pkg::CMD_SUBMIT, 1'($urandom), 32'($urandom_range(0, 9)));
    steady_feed = 1'b0;
  endtask

  // Result side: stall on a rotating pattern that is redrawn now and then,
  // sometimes all ones so stretches without stalls occur too
  initial begin : result_sink
    logic [15:0] pattern;
    int          dwell;
    int          held;
    pattern = '1;
    dwell   = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end
      if (dwell == 0) begin
        case ($urandom_range(0, 3))
          0:       pattern = '1;
          1:       pattern = 16'($urandom) | 16'h0001;
          2:       pattern = (16'($urandom) & 16'($urandom)) | 16'h0100;
          default: pattern = ~(16'h0001 << $urandom_range(0, 15));
        endcase
        dwell = $urandom_range(16, 96);
      end
      dwell--;
      out_tready <= pattern[0];
      pattern = {pattern[0], pattern[15:1]};
    end
  end

  // Compare each taken result with the oldest prediction, field by field
  always @(posedge clk) begin : result_check
    batch_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (slot_results_q.size() == 0) begin
        report_mismatch("result with no request pending", out_tdata, 32'h0);
      end else begin
        want = slot_results_q.pop_front();
        if (out_tdata[4:0] !== want.slot)
          report_mismatch("slot", 32'(out_tdata[4:0]), 32'(want.slot));
        if (out_tuser !== want.flushed)
          report_mismatch("flushed", 32'(out_tuser), 32'(want.flushed));
        if (out_tdata[20:5] !== want.quads)
          report_mismatch("flushed_quads", 32'(out_tdata[20:5]), 32'(want.quads));
        if (out_tdata[26:21] !== want.textures)
          report_mismatch("flushed_textures", 32'(out_tdata[26:21]),
                          32'(want.textures));
        if (out_tdata[31:27] !== 5'h0)
          report_mismatch("tdata padding", 32'(out_tdata[31:27]), 32'h0);
      end
      result_count++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** texture_slot_batcher: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int idx;
    for (idx = 0; idx < SLOT_COUNT; idx++)
      slot_names_q[idx] = '0;
    next_slot_q  = tsb_pkg::NSLOT_W'(1);
    quad_count_q = '0;
    slot_limit_q = tsb_pkg::SLOT_LIMIT_RST;
    quad_cap_q   = tsb_pkg::QUAD_CAP_RST;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_batch_basics();
    test_slot_table_full();
    test_quad_capacity();
    test_random_batches();
    test_output_backpressure();

    // Drain, then leave room for any stray result to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** texture_slot_batcher: PASSED **");
    else
      $display("** texture_slot_batcher: FAILED **");
    $finish;
  end

endmodule
